// File: rtl/core/tgfw_pkg.sv
// Shared types, constants and the 5x7 font for the text framebuffer writer.
package tgfw_pkg;

  localparam int unsigned STORE_BYTES = 1024;
  localparam int unsigned ADDR_W      = 10;
  localparam int unsigned GLYPH_COLS  = 5;
  localparam int unsigned GLYPH_ROWS  = 7;
  localparam int unsigned CELL_STEP   = 6;
  localparam int unsigned LINE_STEP   = 8;

  typedef enum logic [1:0] {
    MODE_CHAR   = 2'd0,
    MODE_CURSOR = 2'd1,
    MODE_FILL   = 2'd2,
    MODE_READ   = 2'd3
  } mode_t;

  // Memory port request from the sequencer.
  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
  } mem_req_t;

  // Column byte of a glyph; col 5 is the blank spacing column.
  function automatic logic [7:0] glyph_column(input logic [7:0] code_in,
                                              input logic [2:0] col);
    logic [7:0]  code;
    logic [39:0] g;
    logic [7:0]  res;
    code = code_in;
    if (code >= 8'h61 && code <= 8'h7A) code = code - 8'd32;
    unique case (code)
      8'h20: g = 40'h00_00_00_00_00;
      8'h30: g = 40'h3E_51_49_45_3E;
      8'h31: g = 40'h00_42_7F_40_00;
      8'h32: g = 40'h42_61_51_49_46;
      8'h33: g = 40'h21_41_45_4B_31;
      8'h34: g = 40'h18_14_12_7F_10;
      8'h35: g = 40'h27_45_45_45_39;
      8'h36: g = 40'h3C_4A_49_49_30;
      8'h37: g = 40'h01_71_09_05_03;
      8'h38: g = 40'h36_49_49_49_36;
      8'h39: g = 40'h06_49_49_29_1E;
      8'h41: g = 40'h7E_11_11_11_7E;
      8'h42: g = 40'h7F_49_49_49_36;
      8'h43: g = 40'h3E_41_41_41_22;
      8'h44: g = 40'h7F_41_41_22_1C;
      8'h45: g = 40'h7F_49_49_49_41;
      8'h46: g = 40'h7F_09_09_09_01;
      8'h47: g = 40'h3E_41_49_49_7A;
      8'h48: g = 40'h7F_08_08_08_7F;
      8'h49: g = 40'h00_41_7F_41_00;
      8'h4A: g = 40'h20_40_41_3F_01;
      8'h4B: g = 40'h7F_08_14_22_41;
      8'h4C: g = 40'h7F_40_40_40_40;
      8'h4D: g = 40'h7F_02_0C_02_7F;
      8'h4E: g = 40'h7F_04_08_10_7F;
      8'h4F: g = 40'h3E_41_41_41_3E;
      8'h50: g = 40'h7F_09_09_09_06;
      8'h51: g = 40'h3E_41_51_21_5E;
      8'h52: g = 40'h7F_09_19_29_46;
      8'h53: g = 40'h46_49_49_49_31;
      8'h54: g = 40'h01_01_7F_01_01;
      8'h55: g = 40'h3F_40_40_40_3F;
      8'h56: g = 40'h1F_20_40_20_1F;
      8'h57: g = 40'h7F_20_18_20_7F;
      8'h58: g = 40'h63_14_08_14_63;
      8'h59: g = 40'h07_08_70_08_07;
      8'h5A: g = 40'h61_51_49_45_43;
      8'h3A: g = 40'h00_36_36_00_00;
      8'h25: g = 40'h63_13_08_64_63;
      8'h2E: g = 40'h00_60_60_00_00;
      8'h2D: g = 40'h08_08_08_08_08;
      8'h2F: g = 40'h20_10_08_04_02;
      default: g = 40'h7C_12_12_12_7C;
    endcase
    unique case (col)
      3'd0: res = g[39:32];
      3'd1: res = g[31:24];
      3'd2: res = g[23:16];
      3'd3: res = g[15:8];
      3'd4: res = g[7:0];
      default: res = 8'h00;
    endcase
    return res & 8'h7F;
  endfunction

endpackage

// File: rtl/core/tgfw_store.sv
// Framebuffer memory: one port, registered read, with a post-reset clearing pass.
module tgfw_store import tgfw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  mem_req_t    req,
  output logic [7:0]  rdata,
  output logic        clearing
);

  logic [7:0]        mem [STORE_BYTES];
  logic [ADDR_W:0]   clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (!clr_cnt[ADDR_W]) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  assign clearing = !clr_cnt[ADDR_W];

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_cnt[ADDR_W-1:0]] <= 8'h00;
    end else if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

// File: rtl/core/tgfw_seq.sv
// Operation sequencer: glyph read-modify-write, fill sweep, read and cursor.
module tgfw_seq import tgfw_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = 128,
  parameter int unsigned SCREEN_HEIGHT = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       clearing,
  input  logic [1:0] mode,
  input  logic [7:0] char_code,
  input  logic [7:0] new_cursor_x,
  input  logic [7:0] new_cursor_y,
  input  logic       fill_on,
  input  logic [ADDR_W-1:0] read_address,
  input  logic [7:0] rdata,
  output mem_req_t   req,
  output logic       busy,
  output logic       done,
  output logic [7:0] read_byte,
  output logic [7:0] cursor_x_now,
  output logic [7:0] cursor_y_now
);

  typedef enum logic [2:0] {
    S_IDLE, S_COL, S_RWAIT, S_WRITE, S_FILL, S_RDWAIT, S_RDDONE
  } state_t;

  localparam logic [7:0] SW = 8'(SCREEN_WIDTH);
  localparam logic [7:0] SH = 8'(SCREEN_HEIGHT);
  localparam logic [7:0] WRAP_LIMIT = 8'(SCREEN_WIDTH - CELL_STEP);

  state_t            state;
  logic [7:0]        code;
  logic [2:0]        col;
  logic              page_hi;
  logic              fill_val;
  logic [ADDR_W-1:0] fcnt;
  logic [7:0]        cx, cy;

  // Current column/page byte address and mask, computed for one column at a time.
  logic [7:0]        px;
  logic [4:0]        pg;
  logic [2:0]        sh;
  logic [14:0]       bits_sh;
  logic [7:0]        pmask, pbits;
  logic [7:0]        vmask;
  logic [12:0]       idx;
  logic              ok;
  logic [7:0]        cx_adv;

  always_comb begin
    px      = cx + 8'(col);
    sh      = cy[2:0];
    pg      = cy[7:3] + 5'(page_hi);
    bits_sh = {7'd0, glyph_column(code, col)} << sh;
    for (int b = 0; b < 8; b++) begin
      vmask[b] = ({pg, 3'(b)} < SH);
    end
    pmask   = page_hi ? 8'({7'h7F} >> (4'd8 - {1'b0, sh})) : 8'(15'h7F << sh);
    if (page_hi && sh == 3'd0) pmask = 8'h00;
    pmask   = pmask & vmask;
    pbits   = page_hi ? {1'b0, bits_sh[14:8]} : bits_sh[7:0];
    idx     = 13'(px) + 13'(pg) * 13'(SCREEN_WIDTH);
    ok      = (px < SW) && ({pg, 3'd0} < SH) && (pmask != 8'h00)
              && (idx < 13'(STORE_BYTES));
    cx_adv  = cx + 8'(CELL_STEP);
  end

  always_comb begin
    req = '0;
    unique case (state)
      S_COL: begin
        req.rd_en = ok;
        req.addr  = idx[ADDR_W-1:0];
      end
      S_WRITE: begin
        req.wr_en = 1'b1;
        req.addr  = idx[ADDR_W-1:0];
        req.wdata = (rdata & ~pmask) | (pbits & pmask);
      end
      S_FILL: begin
        req.wr_en = 1'b1;
        req.addr  = fcnt;
        req.wdata = {8{fill_val}};
      end
      S_RDWAIT: begin
        req.rd_en = 1'b0;
      end
      default: req = '0;
    endcase
    if (state == S_IDLE && start && !clearing && mode_t'(mode) == MODE_READ) begin
      req.rd_en = 1'b1;
      req.addr  = read_address;
    end
  end

  assign busy         = (state != S_IDLE) || clearing;
  assign cursor_x_now = cx;
  assign cursor_y_now = cy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cx        <= '0;
      cy        <= '0;
      done      <= 1'b0;
      read_byte <= '0;
      col       <= '0;
      page_hi   <= 1'b0;
      fcnt      <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start && !clearing) begin
            read_byte <= '0;
            unique case (mode_t'(mode))
              MODE_CHAR: begin
                code    <= char_code;
                col     <= '0;
                page_hi <= 1'b0;
                state   <= S_COL;
              end
              MODE_CURSOR: begin
                cx   <= new_cursor_x;
                cy   <= new_cursor_y;
                done <= 1'b1;
              end
              MODE_FILL: begin
                fill_val <= fill_on;
                fcnt     <= '0;
                state    <= S_FILL;
              end
              MODE_READ: state <= S_RDDONE;
            endcase
          end
        end
        S_COL: begin
          state <= ok ? S_RWAIT : S_WRITE;
          if (!ok) begin
            state <= S_COL;
            if (page_hi) begin
              page_hi <= 1'b0;
              if (col == 3'(GLYPH_COLS)) begin
                state <= S_IDLE;
                done  <= 1'b1;
                if (cx_adv > WRAP_LIMIT) begin
                  cx <= '0;
                  cy <= cy + 8'(LINE_STEP);
                end else begin
                  cx <= cx_adv;
                end
              end else begin
                col <= col + 3'd1;
              end
            end else begin
              page_hi <= 1'b1;
            end
          end
        end
        S_RWAIT: state <= S_WRITE;
        S_WRITE: begin
          state <= S_COL;
          if (page_hi) begin
            page_hi <= 1'b0;
            if (col == 3'(GLYPH_COLS)) begin
              state <= S_IDLE;
              done  <= 1'b1;
              if (cx_adv > WRAP_LIMIT) begin
                cx <= '0;
                cy <= cy + 8'(LINE_STEP);
              end else begin
                cx <= cx_adv;
              end
            end else begin
              col <= col + 3'd1;
            end
          end else begin
            page_hi <= 1'b1;
          end
        end
        S_FILL: begin
          fcnt <= fcnt + 1'b1;
          if (fcnt == ADDR_W'(STORE_BYTES - 1)) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        S_RDDONE: begin
          read_byte <= rdata;
          done      <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/text_glyph_framebuffer_writer_core.sv
// Top level of the text glyph framebuffer writer.
// Usage: raise start with mode and its operands while busy is low; the word is
// taken on that edge. One result word appears with done high for one cycle,
// carrying read_byte (zero unless mode is read) and the cursor after the word.
// The receiver cannot stall; results are never held.
// Steps per operation, set by the single memory port and the column sequencer:
//   set cursor: cursor registered at accept, with done raised alongside it
//   read byte: store read issued at accept, then captured in S_RDDONE
//   fill: all 1024 store bytes, one store byte per cycle
//   character: the accept in S_IDLE, then six columns across two pages,
//   each page byte a read-modify-write through S_COL, S_RWAIT and S_WRITE,
//   or S_COL alone when off screen or masked out
// Reset clears the cursor and starts a clearing pass over all 1024 bytes of the
// store; busy stays high through it.
module text_glyph_framebuffer_writer_core import tgfw_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = 128,
  parameter int unsigned SCREEN_HEIGHT = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output logic        done,
  input  logic [1:0]  mode,
  input  logic [7:0]  char_code,
  input  logic [7:0]  new_cursor_x,
  input  logic [7:0]  new_cursor_y,
  input  logic        fill_on,
  input  logic [9:0]  read_address,
  output logic [7:0]  read_byte,
  output logic [7:0]  cursor_x_now,
  output logic [7:0]  cursor_y_now
);

  mem_req_t   req;
  logic [7:0] rdata;
  logic       clearing;

  tgfw_store u_store (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rdata    (rdata),
    .clearing (clearing)
  );

  tgfw_seq #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .clearing     (clearing),
    .mode         (mode),
    .char_code    (char_code),
    .new_cursor_x (new_cursor_x),
    .new_cursor_y (new_cursor_y),
    .fill_on      (fill_on),
    .read_address (read_address),
    .rdata        (rdata),
    .req          (req),
    .busy         (busy),
    .done         (done),
    .read_byte    (read_byte),
    .cursor_x_now (cursor_x_now),
    .cursor_y_now (cursor_y_now)
  );

endmodule

// File: verif/text_glyph_framebuffer_writer_core_test.sv
// Self-checking testbench for the text glyph framebuffer writer core.
module text_glyph_framebuffer_writer_core_test;
  import tgfw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WIDTH  = 128;
  localparam int unsigned HEIGHT = 64;
  localparam int unsigned STALL_LIMIT = 20000;

  typedef struct packed {
    mode_t      op;
    logic [7:0] code;
    logic [7:0] cx;
    logic [7:0] cy;
    logic       fill;
    logic [9:0] addr;
  } word_t;

  typedef struct packed {
    logic [7:0] rbyte;
    logic [7:0] xnow;
    logic [7:0] ynow;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  logic [1:0] mode = '0;
  logic [7:0] char_code = '0, new_cursor_x = '0, new_cursor_y = '0;
  logic fill_on = 1'b0;
  logic [9:0] read_address = '0;
  logic [7:0] read_byte, cursor_x_now, cursor_y_now;

  text_glyph_framebuffer_writer_core #(.SCREEN_WIDTH(WIDTH), .SCREEN_HEIGHT(HEIGHT)) uut (
    .clk, .rst, .start, .busy, .done, .mode, .char_code, .new_cursor_x, .new_cursor_y,
    .fill_on, .read_address, .read_byte, .cursor_x_now, .cursor_y_now
  );

  always #4 clk = ~clk;

  word_t  pending_words[$];
  reply_t expected_replies[$];
  logic [7:0] pixels[1024];
  logic [7:0] col_pos, row_pos;
  int errors = 0;
  int idle_pct = 38;
  bit hold_sender = 1'b0;
  int stall_count = 0;
  int char_count = 0, read_count = 0, fill_count = 0;

  function automatic logic [39:0] font_bits(input logic [7:0] code_in);
    logic [7:0] c;
    c = code_in;
    if (c >= "a" && c <= "z") c = c - 8'd32;
    case (c)
      " ": return 40'h0000000000;
      "0": return 40'h3E5149453E;  "1": return 40'h00427F4000;
      "2": return 40'h4261514946;  "3": return 40'h2141454B31;
      "4": return 40'h1814127F10;  "5": return 40'h2745454539;
      "6": return 40'h3C4A494930;  "7": return 40'h0171090503;
      "8": return 40'h3649494936;  "9": return 40'h064949291E;
      "A": return 40'h7E1111117E;  "B": return 40'h7F49494936;
      "C": return 40'h3E41414122;  "D": return 40'h7F4141221C;
      "E": return 40'h7F49494941;  "F": return 40'h7F09090901;
      "G": return 40'h3E4149497A;  "H": return 40'h7F0808087F;
      "I": return 40'h00417F4100;  "J": return 40'h2040413F01;
      "K": return 40'h7F08142241;  "L": return 40'h7F40404040;
      "M": return 40'h7F020C027F;  "N": return 40'h7F0408107F;
      "O": return 40'h3E4141413E;  "P": return 40'h7F09090906;
      "Q": return 40'h3E4151215E;  "R": return 40'h7F09192946;
      "S": return 40'h4649494931;  "T": return 40'h01017F0101;
      "U": return 40'h3F4040403F;  "V": return 40'h1F2040201F;
      "W": return 40'h7F2018207F;  "X": return 40'h6314081463;
      "Y": return 40'h0708700807;  "Z": return 40'h6151494543;
      ":": return 40'h0036360000;  "%": return 40'h6313086463;
      ".": return 40'h0060600000;  "-": return 40'h0808080808;
      "/": return 40'h2010080402;
      default: return 40'h7C1212127C;
    endcase
  endfunction

  function automatic void plot(input logic [7:0] x, input logic [7:0] y, input bit on);
    int idx;
    if (x >= WIDTH || y >= HEIGHT) return;
    idx = x + (y / 8) * WIDTH;
    if (idx >= 1024) return;
    pixels[idx][y % 8] = on;
  endfunction

  function automatic reply_t render_word(input word_t w);
    reply_t r;
    logic [39:0] g;
    logic [7:0] colbyte;
    r.rbyte = '0;
    case (w.op)
      MODE_CHAR: begin
        g = font_bits(w.code);
        for (int c = 0; c < 6; c++) begin
          colbyte = (c < 5) ? g[39 - 8*c -: 8] : 8'h00;
          for (int k = 0; k < 7; k++)
            plot(col_pos + 8'(c), row_pos + 8'(k), colbyte[k]);
        end
        col_pos = col_pos + 8'd6;
        if (col_pos > WIDTH - 6) begin
          col_pos = '0;
          row_pos = row_pos + 8'd8;
        end
      end
      MODE_CURSOR: begin
        col_pos = w.cx;
        row_pos = w.cy;
      end
      MODE_FILL: foreach (pixels[i]) pixels[i] = w.fill ? 8'hFF : 8'h00;
      default: r.rbyte = pixels[w.addr];
    endcase
    r.xnow = col_pos;
    r.ynow = row_pos;
    return r;
  endfunction

  function automatic word_t rand_word();
    word_t w;
    int pick;
    w.code = 8'($urandom);
    w.cx   = 8'($urandom);
    w.cy   = 8'($urandom);
    w.fill = 1'($urandom);
    w.addr = 10'($urandom);
    pick = $urandom_range(99);
    if (pick < 55) w.op = MODE_CHAR;
    else if (pick < 70) w.op = MODE_CURSOR;
    else if (pick < 72) w.op = MODE_FILL;
    else w.op = MODE_READ;
    if (w.op == MODE_CURSOR && $urandom_range(3) != 0) begin
      w.cx = 8'($urandom_range(WIDTH + 8));
      w.cy = 8'($urandom_range(HEIGHT + 8));
    end
    if (w.op == MODE_READ && $urandom_range(3) != 0) w.addr = 10'($urandom_range(1023));
    if (w.op == MODE_CHAR && $urandom_range(1) == 0) w.code = 8'($urandom_range(8'h20, 8'h7A));
    return w;
  endfunction

  function automatic word_t make_word(input mode_t op, input logic [7:0] code,
                                      input logic [7:0] cx, input logic [7:0] cy,
                                      input logic fill, input logic [9:0] addr);
    word_t w;
    w.op = op; w.code = code; w.cx = cx; w.cy = cy; w.fill = fill; w.addr = addr;
    return w;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      expected_replies.push_back(render_word(word_t'({mode_t'(mode), char_code, new_cursor_x,
                                                      new_cursor_y, fill_on, read_address})));
      void'(pending_words.pop_front());
      if (pending_words.size() > 0 && !hold_sender && $urandom_range(99) >= idle_pct) begin
        {mode, char_code, new_cursor_x, new_cursor_y, fill_on, read_address} <= pending_words[0];
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end else if (!start && pending_words.size() > 0 && !hold_sender
                 && $urandom_range(99) >= idle_pct) begin
      {mode, char_code, new_cursor_x, new_cursor_y, fill_on, read_address} <= pending_words[0];
      start <= 1'b1;
    end
  end

  always @(posedge clk) begin
    reply_t want;
    if (!rst && done) begin
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected result read_byte=%h x=%h y=%h", $time,
                 read_byte, cursor_x_now, cursor_y_now);
        errors++;
      end else begin
        want = expected_replies.pop_front();
        if (read_byte !== want.rbyte) begin
          $display("%0t: read_byte expected %h actual %h", $time, want.rbyte, read_byte);
          errors++;
        end
        if (cursor_x_now !== want.xnow) begin
          $display("%0t: cursor_x_now expected %h actual %h", $time, want.xnow, cursor_x_now);
          errors++;
        end
        if (cursor_y_now !== want.ynow) begin
          $display("%0t: cursor_y_now expected %h actual %h", $time, want.ynow, cursor_y_now);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy)) stall_count <= 0;
    else stall_count <= stall_count + 1;
    if (stall_count > STALL_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    word_t w;
    foreach (pixels[i]) pixels[i] = 8'h00;
    col_pos = '0;
    row_pos = '0;
    pending_words.push_back(make_word(MODE_READ, 0, 0, 0, 0, 10'd0));
    pending_words.push_back(make_word(MODE_READ, 0, 0, 0, 0, 10'd1023));
    pending_words.push_back(make_word(MODE_CHAR, "A", 0, 0, 0, 0));
    pending_words.push_back(make_word(MODE_CHAR, "z", 0, 0, 0, 0));
    pending_words.push_back(make_word(MODE_CHAR, "/", 0, 0, 0, 0));
    pending_words.push_back(make_word(MODE_CHAR, 8'hFF, 0, 0, 0, 0));
    pending_words.push_back(make_word(MODE_CHAR, 8'h00, 0, 0, 0, 0));
    pending_words.push_back(make_word(MODE_READ, 0, 0, 0, 0, 10'd2));
    pending_words.push_back(make_word(MODE_CURSOR, 0, 8'd120, 8'd60, 0, 0));
    pending_words.push_back(make_word(MODE_CHAR, "%", 0, 0, 0, 0));
    pending_words.push_back(make_word(MODE_CURSOR, 0, 8'd254, 8'd254, 0, 0));
    pending_words.push_back(make_word(MODE_CHAR, "8", 0, 0, 0, 0));
    pending_words.push_back(make_word(MODE_CURSOR, 0, 8'd255, 8'd255, 0, 0));
    pending_words.push_back(make_word(MODE_FILL, 0, 0, 0, 1'b1, 0));
    pending_words.push_back(make_word(MODE_READ, 0, 0, 0, 0, 10'd1023));
    pending_words.push_back(make_word(MODE_CHAR, "-", 0, 0, 0, 0));
    pending_words.push_back(make_word(MODE_READ, 0, 0, 0, 0, 10'd0));
    pending_words.push_back(make_word(MODE_READ, 0, 0, 0, 0, 10'd1));
    pending_words.push_back(make_word(MODE_CURSOR, 0, 8'd122, 8'd0, 0, 0));
    pending_words.push_back(make_word(MODE_CHAR, ".", 0, 0, 0, 0));
    pending_words.push_back(make_word(MODE_READ, 0, 0, 0, 0, 10'd122));
    pending_words.push_back(make_word(MODE_FILL, 0, 0, 0, 1'b0, 0));
    pending_words.push_back(make_word(MODE_READ, 0, 0, 0, 0, 10'd512));
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    wait (pending_words.size() == 0);
    hold_sender = 1'b1;
    wait (expected_replies.size() == 0);
    hold_sender = 1'b0;
    for (int n = 0; n < 900; n++) begin
      w = rand_word();
      if (w.op == MODE_CHAR) char_count++;
      else if (w.op == MODE_READ) read_count++;
      else if (w.op == MODE_FILL) fill_count++;
      pending_words.push_back(w);
      if (n == 300) idle_pct = 0;
      if (n == 500) idle_pct = 38;
      if (n % 100 == 99) begin
        wait (pending_words.size() == 0);
      end
    end
    wait (pending_words.size() == 0);
    wait (expected_replies.size() == 0);
    repeat (1100) @(posedge clk);
    $display("Covered directed corners plus 900 random words: %0d chars, %0d reads, %0d fills.",
             char_count, read_count, fill_count);
    if (errors == 0 && expected_replies.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
